>>> rtl/assert_macros.svh
// Assertion macros for the RTL, included by the CRC engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds on every clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression never holds on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

>>> rtl/crc16ce_pkg.sv
// Constants and CRC helper functions for the CRC-16 byte engine.
package crc16ce_pkg;

    localparam int unsigned CRC_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 8;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_POLYNOMIAL    = 8'd0;
    localparam logic [IDX_W-1:0] REG_SHIFT_DIR     = 8'd1;
    localparam logic [IDX_W-1:0] REG_BYTE_XFORM    = 8'd2;
    localparam logic [IDX_W-1:0] REG_INITIAL_VALUE = 8'd3;

    // Bits of the byte transform register
    localparam int unsigned XFORM_SWAP_BIT    = 0;
    localparam int unsigned XFORM_REVERSE_BIT = 1;

    localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0] TOP_BIT    = 16'h8000;

    function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] reverse16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // Eight bit steps of the CRC for one byte, in either shift direction.
    function automatic logic [CRC_W-1:0] crc_absorb(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly,
        input logic              reflected
    );
        logic [CRC_W-1:0] c;
        logic [CRC_W-1:0] rp;
        rp = reverse16(poly);
        if (!reflected) begin
            c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
            for (int k = 0; k < BYTE_W; k++) begin
                c = ((c & TOP_BIT) != '0) ? ({c[CRC_W-2:0], 1'b0} ^ poly)
                                          : {c[CRC_W-2:0], 1'b0};
            end
        end else begin
            c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
            for (int k = 0; k < BYTE_W; k++) begin
                c = c[0] ? ({1'b0, c[CRC_W-1:1]} ^ rp) : {1'b0, c[CRC_W-1:1]};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/crc16_configurable_byte_engine_unit.sv
// CRC-16 byte engine with configurable polynomial, direction, byte transform and seed.
// The CRC appears on m_tdata in the cycle after the last word is accepted; when that
// word completes a swapped pair, it follows once the pending state absorbs the held byte.
// Throughput: one word per cycle while the output slot is free; a completed swapped pair
// reuses the single byte CRC unit in its pending state; there only a word that gets held is taken, others wait.
// Reset (aresetn low, synchronous): control registers take their reset values, CRC = seed.
`include "assert_macros.svh"
module crc16_configurable_byte_engine_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [crc16ce_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // last_byte
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [crc16ce_pkg::CRC_W-1:0]    m_tdata,   // [15:0] crc_value
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crc16ce_pkg::IDX_W-1:0]    cfg_index,
    input  logic [crc16ce_pkg::CRC_W-1:0]    cfg_data
);
    import crc16ce_pkg::*;

    logic [CRC_W-1:0]  poly_reg, poly_next;
    logic              dir_reg, dir_next;
    logic [1:0]        xform_reg, xform_next;
    logic [CRC_W-1:0]  init_reg, init_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic              pend_last_reg, pend_last_next;
    logic              pending_reg, pending_next;
    logic              m_valid_reg, m_valid_next;
    logic [CRC_W-1:0]  m_data_reg, m_data_next;

    logic              out_free;
    logic              advance;
    logic              swap_on;
    logic              in_acc;
    logic              cfg_acc;
    logic              emit;
    logic [BYTE_W-1:0] raw_byte;
    logic [BYTE_W-1:0] crc_byte;
    logic [CRC_W-1:0]  crc_step;

    assign out_free  = !m_valid_reg || m_tready;
    // a pending pair ending a message needs the output slot
    assign advance   = pending_reg && (!pend_last_reg || out_free);
    assign swap_on   = xform_reg[XFORM_SWAP_BIT];
    // while the second half of a pair is absorbed, take only a word that gets held
    assign s_tready  = pending_reg ? (advance && swap_on && !s_tlast) : out_free;
    assign cfg_ready = !pending_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign raw_byte  = pending_reg ? pend_byte_reg : s_tdata;
    assign crc_byte  = xform_reg[XFORM_REVERSE_BIT] ? reverse8(raw_byte) : raw_byte;
    assign crc_step  = crc_absorb(crc_reg, crc_byte, poly_reg, dir_reg);

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        poly_next       = poly_reg;
        dir_next        = dir_reg;
        xform_next      = xform_reg;
        init_next       = init_reg;
        crc_next        = crc_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_last_next  = pend_last_reg;
        pending_next    = pending_reg;
        emit            = 1'b0;

        // finish the pair: absorb the held byte after the new one
        if (advance) begin
            pending_next = 1'b0;
            if (pend_last_reg) begin
                emit     = 1'b1;
                crc_next = init_reg;
            end else begin
                crc_next = crc_step;
            end
        end

        if (in_acc) begin
            priority if (pending_reg) begin
                held_byte_next  = s_tdata;
                held_valid_next = 1'b1;
            end else if (held_valid_reg) begin
                crc_next        = crc_step;
                pending_next    = 1'b1;
                pend_byte_next  = held_byte_reg;
                pend_last_next  = s_tlast;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
            end else if (swap_on && !s_tlast) begin
                held_byte_next  = s_tdata;
                held_valid_next = 1'b1;
            end else if (s_tlast) begin
                emit     = 1'b1;
                crc_next = init_reg;
            end else begin
                crc_next = crc_step;
            end
        end

        if (cfg_acc) begin
            unique case (cfg_index)
                REG_POLYNOMIAL:    poly_next  = cfg_data;
                REG_SHIFT_DIR:     dir_next   = cfg_data[0];
                REG_BYTE_XFORM:    xform_next = cfg_data[1:0];
                REG_INITIAL_VALUE: begin
                    init_next = cfg_data;
                    crc_next  = cfg_data;
                end
                default: ;
            endcase
        end

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = crc_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg       <= POLY_RESET;
            dir_reg        <= 1'b0;
            xform_reg      <= 2'b00;
            init_reg       <= '0;
            crc_reg        <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            poly_reg       <= poly_next;
            dir_reg        <= dir_next;
            xform_reg      <= xform_next;
            init_reg       <= init_next;
            crc_reg        <= crc_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            pend_last_reg  <= pend_last_next;
            pending_reg    <= pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg <= pend_byte_next;
        m_data_reg    <= m_data_next;
    end

    `ASSERT_NEVER(a_held_pend, aclk, aresetn, held_valid_reg && pending_reg, "hold in pair")
    `ASSERT_NEVER(a_emit_ovr, aclk, aresetn, emit && m_valid_reg && !m_tready, "result lost")
    `ASSERT_NEVER(a_cfg_pend, aclk, aresetn, cfg_ready && pending_reg, "cfg in pair")
    `ASSERT_AT(a_pair_done, aclk, aresetn, advance |=> !pending_reg, "pair stuck")

endmodule

>>> dv/crc16_configurable_byte_engine_unit_test.sv
// Self-checking bench for the CRC-16 byte engine: a directed plan, then random messages.
module crc16_configurable_byte_engine_unit_test;
    import crc16ce_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int BYTE_BUDGET   = 920;
    localparam int IDLE_PCT      = 11;
    localparam int PLAN_ROWS     = 33;

    typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_BYTE_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   addr;
        logic [CRC_W-1:0]   value;
        logic               last;
        logic [CRC_W-1:0]   crc;
    } plan_row_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata   = '0;
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [CRC_W-1:0]   m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CRC_W-1:0]   cfg_data  = '0;

    // Predicted engine state
    logic [CRC_W-1:0]   crc_poly      = POLY_RESET;
    logic               crc_reflected = 1'b0;
    logic [1:0]         crc_xform     = 2'b00;
    logic [CRC_W-1:0]   crc_seed      = '0;
    logic [CRC_W-1:0]   crc_run       = '0;
    logic [BYTE_W-1:0]  pair_byte     = '0;
    logic               pair_held     = 1'b0;

    logic [CRC_W-1:0]   crc_due_q[$];

    logic stream_open = 1'b0;
    logic cfg_open    = 1'b0;
    logic steady      = 1'b0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   fail_count  = 0;
    int   crc_seen    = 0;
    int   bytes_sent  = 0;
    int   messages_done = 0;
    int   writes_done = 0;
    int   quiet_cycles = 0;
    int   phase       = 0;

    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{ROW_BYTE_TYPED, 8'h00,             16'h0000, 1'b1, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0031, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0032, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0039, 1'b1, 16'h0000},
        '{ROW_WRITE,      REG_POLYNOMIAL,    16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_INITIAL_VALUE, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_BYTE_TYPED, 8'h00,             16'h00FF, 1'b1, 16'hFF00},
        '{ROW_WRITE,      REG_POLYNOMIAL,    16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_SHIFT_DIR,     16'hFFFF, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0080, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0001, 1'b1, 16'h0000},
        '{ROW_WRITE,      REG_INITIAL_VALUE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_BYTE_XFORM,    16'h0001, 1'b0, 16'h0000},
        // single last byte under swap goes through alone
        '{ROW_BYTE,       8'h00,             16'h0000, 1'b1, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h00A5, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h005A, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h00C3, 1'b1, 16'h0000},
        '{ROW_WRITE,      REG_BYTE_XFORM,    16'h0003, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0012, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0034, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0056, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0078, 1'b1, 16'h0000},
        // clear the swap while a byte is held: the pair still completes swapped
        '{ROW_BYTE,       8'h00,             16'h00F0, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_BYTE_XFORM,    16'h0002, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h000F, 1'b1, 16'h0000},
        '{ROW_WRITE,      REG_SHIFT_DIR,     16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_BYTE_XFORM,    16'h0000, 1'b0, 16'h0000},
        // seed write in the middle of a message reloads the CRC at once
        '{ROW_BYTE,       8'h00,             16'h0011, 1'b0, 16'h0000},
        '{ROW_WRITE,      REG_INITIAL_VALUE, 16'hABCD, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h0022, 1'b1, 16'h0000},
        // writes to unknown indexes change nothing
        '{ROW_WRITE,      8'h04,             16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,      8'hFF,             16'h0000, 1'b0, 16'h0000},
        '{ROW_BYTE,       8'h00,             16'h003C, 1'b1, 16'h0000}
    };

    crc16_configurable_byte_engine_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) r = {r[BYTE_W-2:0], v[i]};
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] mirror16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        r = '0;
        for (int i = 0; i < CRC_W; i++) r = {r[CRC_W-2:0], v[i]};
        return r;
    endfunction

    // Feed one byte into the running CRC, one message bit at a time.
    task automatic fold_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        logic [CRC_W-1:0]  rpoly;
        logic              fb;
        b = crc_xform[XFORM_REVERSE_BIT] ? mirror8(raw) : raw;
        rpoly = mirror16(crc_poly);
        for (int k = 0; k < BYTE_W; k++) begin
            if (!crc_reflected) begin
                fb = crc_run[CRC_W-1] ^ b[BYTE_W-1-k];
                crc_run = {crc_run[CRC_W-2:0], 1'b0} ^ ({CRC_W{fb}} & crc_poly);
            end else begin
                fb = crc_run[0] ^ b[k];
                crc_run = {1'b0, crc_run[CRC_W-1:1]} ^ ({CRC_W{fb}} & rpoly);
            end
        end
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] d, input logic l,
                                output logic emits, output logic [CRC_W-1:0] crc);
        emits = 1'b0;
        crc = '0;
        if (pair_held) begin
            // partner first, then the held even byte
            fold_byte(d);
            fold_byte(pair_byte);
            pair_held = 1'b0;
            pair_byte = '0;
        end else if (crc_xform[XFORM_SWAP_BIT] && !l) begin
            pair_byte = d;
            pair_held = 1'b1;
        end else begin
            fold_byte(d);
        end
        if (l) begin
            emits = 1'b1;
            crc = crc_run;
            crc_run = crc_seed;
            pair_held = 1'b0;
            pair_byte = '0;
        end
    endtask

    task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        case (idx)
            REG_POLYNOMIAL: crc_poly = val;
            REG_SHIFT_DIR: crc_reflected = val[0];
            REG_BYTE_XFORM: crc_xform = val[1:0];
            REG_INITIAL_VALUE: begin
                crc_seed = val;
                crc_run = val;
            end
            default: ;
        endcase
    endtask

    // Drop the input stream, drain all CRC words, let the engine finish any pair.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        stream_open = 1'b0;
        while (crc_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        if (stream_open) settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_open = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_write(idx, val);
        writes_done++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l,
                             input logic typed, input logic [CRC_W-1:0] typed_crc);
        int               gap;
        logic             emits;
        logic [CRC_W-1:0] crc;
        gap = 0;
        if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
        if (cfg_open) begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        stream_open = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_byte(d, l, emits, crc);
        if (emits) begin
            crc_due_q.push_back(typed ? typed_crc : crc);
            messages_done++;
        end
        bytes_sent++;
    endtask

    task automatic random_phase(input int ph);
        int               n_writes;
        int               n_msgs;
        int               len;
        logic             cut;
        logic [IDX_W-1:0] idx;
        logic [CRC_W-1:0] val;
        logic [BYTE_W-1:0] d;
        steady = (ph >= 15 && ph < 30);
        n_writes = ($urandom_range(99) < 70) ? $urandom_range(1, 5) : 0;
        for (int w = 0; w < n_writes; w++) begin
            idx = ($urandom_range(99) < 90) ? IDX_W'($urandom_range(0, 3))
                                            : IDX_W'($urandom_range(4, 255));
            if ($urandom_range(99) < 25) val = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else val = CRC_W'($urandom_range(0, 65535));
            write_reg(idx, val);
        end
        n_msgs = $urandom_range(1, 5);
        // stall the result side while many short messages keep coming
        if (ph == 6 || ph == 40) begin
            hold_asked++;
            n_msgs = 14;
        end
        for (int m = 0; m < n_msgs; m++) begin
            len = ($urandom_range(99) < 10) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            cut = (m == n_msgs - 1) && ($urandom_range(99) < 15);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(99) < 10) d = $urandom_range(1) ? 8'hFF : 8'h00;
                else d = BYTE_W'($urandom_range(0, 255));
                push_byte(d, !cut && (j == len - 1), 1'b0, '0);
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        logic [CRC_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (crc_due_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected crc word: got %h", m_tdata);
            end else begin
                want = crc_due_q.pop_front();
                crc_seen++;
                if (m_tdata !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("crc mismatch: expected %h, got %h", want, m_tdata);
                end
            end
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL crc16_configurable_byte_engine_unit");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (opening_plan[r].kind == ROW_WRITE)
                write_reg(opening_plan[r].addr, opening_plan[r].value);
            else
                push_byte(opening_plan[r].value[BYTE_W-1:0], opening_plan[r].last,
                          opening_plan[r].kind == ROW_BYTE_TYPED, opening_plan[r].crc);
        end
        while (bytes_sent < BYTE_BUDGET) begin
            random_phase(phase);
            phase++;
        end
        settle_idle();
        $display("run covered %0d bytes in %0d messages over %0d phases, %0d register writes",
                 bytes_sent, messages_done, phase, writes_done);
        $display("%0d crc words checked across all transforms, both directions, with hold-offs",
                 crc_seen);
        if (fail_count == 0) begin
            $display("PASS crc16_configurable_byte_engine_unit");
        end else begin
            $display("FAIL crc16_configurable_byte_engine_unit");
        end
        $finish;
    end

endmodule

>>> crc16_configurable_byte_engine_unit.f
+incdir+rtl
rtl/crc16ce_pkg.sv
rtl/crc16_configurable_byte_engine_unit.sv
dv/crc16_configurable_byte_engine_unit_test.sv
